### rtl/ihcg_pkg.sv
// Shared constants, types and table function for the Ih channel gating pipeline.
package ihcg_pkg;

   localparam int EXP_TABLE_DEPTH_DEF = 256;

   // Exponent argument, Q16 signed.
   localparam int XW = 23;
   // Exponential result, Q32 unsigned.
   localparam int EW = 62;

   localparam logic [63:0] LN2_Q30 = 64'd744261118;
   localparam logic [63:0] Q30_ONE = 64'd1073741824;
   localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;

   localparam logic signed [22:0] C_A1_OFS = -23'sd956170;
   localparam logic signed [21:0] C_A1_SLOPE = 22'sd1442841;
   localparam logic signed [22:0] C_A2_OFS = -23'sd122552;
   localparam logic signed [21:0] C_A2_SLOPE = 22'sd1176083;
   localparam logic signed [22:0] C_INV_SLOPE = 23'sd3050403;

   localparam logic signed [XW-1:0] EXP_ARG_MIN = -23'sd2621440;
   localparam logic signed [XW-1:0] EXP_ARG_MAX = 23'sd1310720;

   // Register indexes.
   localparam logic [1:0] REG_HALF_V = 2'd0;
   localparam logic [1:0] REG_PEAK_G = 2'd1;
   localparam logic [1:0] REG_REV_V = 2'd2;

   localparam logic [15:0] HALF_V_RST = 16'hB000;
   localparam logic [15:0] REV_V_RST = 16'hD800;

   // Quotient bits of the steady-state divide.
   localparam int QW = 25;
   localparam int RW = 34;

   typedef struct packed {
      logic [15:0] m;
      logic [31:0] g;
      logic signed [49:0] curp;
      logic zneg;
   } side_type;

   typedef struct packed {
      logic [RW-1:0] r;
      logic [RW-1:0] d;
      logic [QW-1:0] nlo;
      logic [QW-1:0] q;
      logic [35:0] rr;
   } div_type;

   // Taylor sum of exp(t / 2^30), Q30, terms floored.
   function automatic logic [63:0] exp_rom_entry(input logic [63:0] t);
      logic [63:0] sum;
      logic [63:0] term;
      sum = Q30_ONE;
      term = Q30_ONE;
      for (int n = 1; n <= 12; n++) begin
         term = ((term * t) >> 30) / 64'(n);
         sum = sum + term;
      end
      return sum;
   endfunction

endpackage

### rtl/ihcg_exp.sv
// Pipelined fixed-point exponential: table lookup, interpolation and shift.
module ihcg_exp import ihcg_pkg::*; #(
   parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 adv,
   input  logic signed [XW-1:0] x_in,
   output logic [EW-1:0]        e_out
);

   localparam int IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int PW = 16 + IDX_W;

   logic [31:0] rom [0:EXP_TABLE_DEPTH];

   for (genvar i = 0; i <= EXP_TABLE_DEPTH; i++) begin : g_rom
      localparam logic [63:0] T_ARG = (64'(i) * LN2_Q30) / 64'(EXP_TABLE_DEPTH);
      localparam logic [63:0] T_VAL = exp_rom_entry(T_ARG);
      assign rom[i] = T_VAL[31:0];
   end

   logic signed [XW-1:0] xc_ff, xc_in;
   logic signed [XW-1:0] y_ff, y_in;
   logic signed [54:0]   y_prod;
   logic signed [6:0]    k3_ff, k4_ff, k5_ff, k6_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     idx_nx;
   logic [15:0]          w3_ff, w4_ff;
   logic [PW-1:0]        p_v;
   logic [31:0]          a4_ff, b4_ff, a5_ff, t5_ff, mant_ff;
   logic [47:0]          t_prod;
   logic signed [7:0]    s_v;
   logic [6:0]           neg_v;
   logic [63:0]          sh_v;
   logic [EW-1:0]        e_ff;

   // clamp
   always_comb begin
      if (x_in < EXP_ARG_MIN) begin
         xc_in = EXP_ARG_MIN;
      end else if (x_in > EXP_ARG_MAX) begin
         xc_in = EXP_ARG_MAX;
      end else begin
         xc_in = x_in;
      end
   end

   assign y_prod = xc_ff * LOG2E_Q30;
   assign y_in = XW'(y_prod >>> 30);
   assign p_v = PW'(y_ff[15:0]) * PW'(EXP_TABLE_DEPTH);
   assign idx_nx = idx_ff + IDX_W'(1);
   assign t_prod = 48'(b4_ff - a4_ff) * 48'(w4_ff);

   always_comb begin
      s_v = 8'(k6_ff) + 8'sd2;
      neg_v = 7'(-s_v);
      if (s_v >= 0) begin
         sh_v = 64'(mant_ff) << s_v[4:0];
      end else begin
         sh_v = 64'(mant_ff) >> neg_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xc_ff <= xc_in;
         y_ff <= y_in;
         k3_ff <= y_ff[XW-1:16];
         idx_ff <= p_v[PW-1:16];
         w3_ff <= p_v[15:0];
         a4_ff <= rom[idx_ff];
         b4_ff <= rom[idx_nx];
         w4_ff <= w3_ff;
         k4_ff <= k3_ff;
         a5_ff <= a4_ff;
         t5_ff <= t_prod[47:16];
         k5_ff <= k4_ff;
         mant_ff <= a5_ff + t5_ff;
         k6_ff <= k5_ff;
         e_ff <= sh_v[EW-1:0];
      end
   end

   assign e_out = e_ff;

endmodule

### rtl/ih_channel_gating_rate.sv
// An accepted item passes the input, argument, exp, divide and derivative stages
// to the rsp channel. Throughput: one item per cycle unless the output stalls;
// the exp units (7 stages each) and the 25-stage restoring divider for the steady
// gate value set the depth. The whole pipeline holds while a result waits on the
// output register. Reset (synchronous) clears all valid bits and loads register defaults.
module ih_channel_gating_rate import ihcg_pkg::*; #(
   parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_membrane_v,
   input  logic [15:0]        req_gate_m,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_gate_rate,
   output logic [31:0]        rsp_conductance,
   output logic signed [47:0] rsp_channel_current,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int NST = 39;
   localparam int DIV_ST = 10;

   logic adv;
   logic [NST:1] vld_ff;

   logic signed [15:0] half_v_ff, rev_v_ff;
   logic [31:0]        peak_g_ff;

   // stage 1
   logic signed [15:0] v1_ff;
   logic [15:0]        m1_ff;
   // stage 2
   logic signed [37:0] a1_prod, a2_prod;
   logic signed [16:0] vd_v;
   logic signed [39:0] z_prod;
   logic [47:0]        g_prod;
   logic signed [XW-1:0] a1_ff, a2_ff, z_ff, xz_v;
   logic [31:0]        g2_ff;
   logic signed [16:0] dv2_ff;
   logic [15:0]        m2_ff;
   // exp results
   logic [EW-1:0] e1_v, e2_v, ez_v;
   logic [43:0]   rsum_v;

   side_type side_ff [3:NST-1];
   div_type  div_ff [0:QW];
   div_type  div_in [1:QW];

   logic signed [25:0] diff_ff;
   logic [35:0]        rr_ff;
   logic signed [44:0] plo_ff, phi_ff;
   logic signed [62:0] prod_ff;
   logic signed [38:0] rate_v;
   side_type           last_v;

   assign adv = !vld_ff[NST] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[NST];

   always_ff @(posedge clock) begin
      if (reset) begin
         half_v_ff <= HALF_V_RST;
         peak_g_ff <= '0;
         rev_v_ff <= REV_V_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_HALF_V: half_v_ff <= csr_wdata[15:0];
            REG_PEAK_G: peak_g_ff <= csr_wdata;
            REG_REV_V:  rev_v_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-1:1], req_valid};
      end
   end

   // exponent arguments, conductance and driving force
   assign a1_prod = v1_ff * C_A1_SLOPE;
   assign a2_prod = v1_ff * C_A2_SLOPE;
   assign vd_v = 17'(v1_ff) - 17'(half_v_ff);
   assign z_prod = vd_v * C_INV_SLOPE;
   assign g_prod = 48'(peak_g_ff) * 48'(m1_ff);
   assign xz_v = z_ff[XW-1] ? z_ff : -z_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         v1_ff <= req_membrane_v;
         m1_ff <= req_gate_m;
         a1_ff <= XW'(38'(C_A1_OFS) - (a1_prod >>> 16));
         a2_ff <= XW'(38'(C_A2_OFS) + (a2_prod >>> 16));
         z_ff <= XW'(z_prod >>> 16);
         g2_ff <= g_prod[47:16];
         dv2_ff <= 17'(rev_v_ff) - 17'(v1_ff);
         m2_ff <= m1_ff;
         side_ff[3].m <= m2_ff;
         side_ff[3].g <= g2_ff;
         side_ff[3].curp <= $signed({1'b0, g2_ff}) * dv2_ff;
         side_ff[3].zneg <= z_ff[XW-1];
         for (int i = 4; i <= NST - 1; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   ihcg_exp #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_a1 (
      .clock(clock), .adv(adv), .x_in(a1_ff), .e_out(e1_v)
   );
   ihcg_exp #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_a2 (
      .clock(clock), .adv(adv), .x_in(a2_ff), .e_out(e2_v)
   );
   ihcg_exp #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_z (
      .clock(clock), .adv(adv), .x_in(xz_v), .e_out(ez_v)
   );

   assign rsum_v = e1_v[43:0] + e2_v[43:0];

   // restoring divide, one quotient bit per stage
   for (genvar j = 1; j <= QW; j++) begin : g_div
      logic [RW-1:0] rs;
      assign rs = {div_ff[j-1].r[RW-2:0], div_ff[j-1].nlo[QW-1]};
      always_comb begin
         div_in[j] = div_ff[j-1];
         div_in[j].nlo = {div_ff[j-1].nlo[QW-2:0], 1'b0};
         if (rs >= div_ff[j-1].d) begin
            div_in[j].r = rs - div_ff[j-1].d;
            div_in[j].q = {div_ff[j-1].q[QW-2:0], 1'b1};
         end else begin
            div_in[j].r = rs;
            div_in[j].q = {div_ff[j-1].q[QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0].d <= (RW'(1) << 32) + RW'(ez_v[32:0]);
         div_ff[0].r <= side_ff[DIV_ST-1].zneg ? (RW'(1) << 31) : RW'(ez_v[32:1]);
         div_ff[0].nlo <= {!side_ff[DIV_ST-1].zneg && ez_v[0], 24'd0};
         div_ff[0].q <= '0;
         div_ff[0].rr <= rsum_v[43:8];
         for (int j = 1; j <= QW; j++) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   // derivative product, split over two partial products
   assign rate_v = 39'(prod_ff >>> 24);
   assign last_v = side_ff[NST-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         diff_ff <= $signed({1'b0, div_ff[QW].q}) -
                    $signed({2'b0, side_ff[DIV_ST+QW].m, 8'd0});
         rr_ff <= div_ff[QW].rr;
         plo_ff <= diff_ff * $signed({1'b0, rr_ff[17:0]});
         phi_ff <= diff_ff * $signed({1'b0, rr_ff[35:18]});
         prod_ff <= (63'(phi_ff) <<< 18) + 63'(plo_ff);
         if (rate_v[38:31] == {8{rate_v[38]}}) begin
            rsp_gate_rate <= rate_v[31:0];
         end else begin
            rsp_gate_rate <= rate_v[38] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
         end
         rsp_conductance <= last_v.g;
         if (last_v.curp[49:47] == {3{last_v.curp[49]}}) begin
            rsp_channel_current <= last_v.curp[47:0];
         end else begin
            rsp_channel_current <= last_v.curp[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
         end
      end
   end

endmodule

### rtl/ihcg_checker.sv
// Port-level checks for the Ih channel gating pipeline, bound to the top level.
module ihcg_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_gate_rate,
   input logic [31:0]        rsp_conductance,
   input logic signed [47:0] rsp_channel_current
);

   // a waiting item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable(rsp_gate_rate) && $stable(rsp_conductance) &&
      $stable(rsp_channel_current))
      else $error("rsp item changed while stalled");

   // empty output never blocks input
   a_ready_free: assert property (@(posedge clock)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output");

   // stalled output blocks input
   a_ready_stall: assert property (@(posedge clock)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req_ready high during output stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind ih_channel_gating_rate ihcg_checker u_ihcg_checker (.*);
